### rtl/emboss_gray_filter_macros.svh
// Assertion macros shared by the emboss filter RTL.
// Plain text only; taken in by the modules that carry assertions.
`ifndef EMBOSS_GRAY_FILTER_MACROS_SVH
`define EMBOSS_GRAY_FILTER_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset
`define EMB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset
`define EMB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/emb_pkg.sv
// Package for the emboss filter: beat type, register indexes and helpers.
// No dependencies; used by every module of the block.
package emb_pkg;

  // Configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_DW    = 16;   // widest register
  localparam int FW_W      = 11;   // frame_width field
  localparam int FH_W      = 16;   // frame_height field
  localparam int NCH       = 3;    // colour channels, one cell each
  localparam logic [7:0] GRAY_MID = 8'd128;
  localparam logic [7:0] GRAY_MAX = 8'hFF;
  localparam logic [FH_W-1:0] HEIGHT_LAST_RST = 16'd1023;

  // Beat handed along the row of cells
  typedef struct packed {
    logic              vld;
    logic              last;   // last pixel of the frame
    logic              flat;   // top row or left column: mid gray
    logic [7:0]        alpha;
    logic [23:0]       cur;    // pixel RGB, channel under test in 23:16
    logic [23:0]       ul;     // upper-left RGB, same alignment
    logic signed [8:0] best;   // winning difference so far
  } emb_beat_t;

  // Magnitude of a channel difference (range -255..255)
  function automatic logic [8:0] emb_mag(input logic signed [8:0] v);
    logic [8:0] r;
    r = v[8] ? 9'(-v) : 9'(v);
    return r;
  endfunction

endpackage

### rtl/emb_cell.sv
// One comparison cell of the emboss chain: tests the channel in bits 23:16.
// Depends on emb_pkg.
module emb_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  emb_pkg::emb_beat_t beat_i,
  output emb_pkg::emb_beat_t beat_o
);

  emb_pkg::emb_beat_t beat_r;
  emb_pkg::emb_beat_t beat_nxt;
  logic signed [8:0]  diff;

  // neighbour minus pixel for this channel; strict compare keeps earlier on ties
  assign diff = 9'(beat_i.ul[23:16]) - 9'(beat_i.cur[23:16]);

  always_comb begin
    beat_nxt      = beat_i;
    beat_nxt.cur  = {beat_i.cur[15:0], 8'h00};
    beat_nxt.ul   = {beat_i.ul[15:0], 8'h00};
    beat_nxt.best = (emb_pkg::emb_mag(diff) > emb_pkg::emb_mag(beat_i.best)) ?
                    diff : beat_i.best;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_o = beat_r;

endmodule

### rtl/emb_front.sv
// Front stage: frame size registers, row/column counters and the line store.
// Depends on emb_pkg and emboss_gray_filter_macros.svh.
`include "emboss_gray_filter_macros.svh"
module emb_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_tvalid,
  input  logic [31:0]                in_tdata,
  input  logic                       cfg_wen,
  input  logic                       cfg_addr,
  input  logic [emb_pkg::CFG_DW-1:0] cfg_wdata,
  output emb_pkg::emb_beat_t         beat_o
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [CW-1:0]               width_last_r, width_last_nxt;
  logic [emb_pkg::FH_W-1:0]    height_last_r, height_last_nxt;
  logic [CW-1:0]               col_r;
  logic [emb_pkg::FH_W-1:0]    row_r;
  logic [23:0]                 rd_r;          // upper-left hold
  logic [23:0]                 mem [MAX_WIDTH];
  logic [emb_pkg::FW_W-1:0]    wv;
  logic [emb_pkg::FH_W-1:0]    hv;
  emb_pkg::emb_beat_t          beat_r;
  logic                        acc;
  logic                        row_end;
  logic                        last;

  assign acc = en & in_tvalid;
  assign wv  = cfg_wdata[emb_pkg::FW_W-1:0];
  assign hv  = cfg_wdata[emb_pkg::FH_W-1:0];

  // size registers kept as last column / last row, clamped at write time
  always_comb begin
    width_last_nxt  = width_last_r;
    height_last_nxt = height_last_r;
    if (cfg_wen) begin
      unique case (cfg_addr)
        emb_pkg::CFG_FRAME_WIDTH: begin
          if (wv == '0) begin
            width_last_nxt = '0;
          end else if (int'(wv) > MAX_WIDTH) begin
            width_last_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            width_last_nxt = CW'(wv - 1'b1);
          end
        end
        emb_pkg::CFG_FRAME_HEIGHT: begin
          height_last_nxt = (hv == '0) ? '0 : hv - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= CW'(RST_W - 1);
      height_last_r <= emb_pkg::HEIGHT_LAST_RST;
    end else begin
      width_last_r  <= width_last_nxt;
      height_last_r <= height_last_nxt;
    end
  end

  // position in the frame
  assign row_end = (col_r >= width_last_r);
  assign last    = row_end & (row_r >= height_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= last ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // line store: read the row above, then overwrite with this pixel
  always_ff @(posedge clk) begin
    if (acc) begin
      mem[col_r] <= in_tdata[31:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
    end else if (acc) begin
      rd_r <= mem[col_r];
    end
  end

  // stage register feeding the cell row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (en) begin
      beat_r.vld   <= in_tvalid;
      beat_r.last  <= last;
      beat_r.flat  <= (row_r == '0) | (col_r == '0);
      beat_r.alpha <= in_tdata[7:0];
      beat_r.cur   <= in_tdata[31:8];
      beat_r.ul    <= rd_r;
      beat_r.best  <= '0;
    end
  end

  assign beat_o = beat_r;

  // checks
  `EMB_ASSERT_NEXT(a_wrap_at_frame_end, clk, rst_n, acc && last, (col_r == '0) && (row_r == '0), "counters did not wrap at frame end")
  `EMB_ASSERT_NEXT(a_edge_is_flat, clk, rst_n, acc && (col_r == '0), beat_r.vld && beat_r.flat, "left column pixel not marked flat")
  `EMB_ASSERT_NEXT(a_hold_kept, clk, rst_n, !acc, $stable(rd_r), "upper-left hold moved without a beat")

endmodule

### rtl/emb_out.sv
// Output stage: clamps 128 plus the winning difference, owns the result register.
// Flat beats give mid gray instead. Depends on emb_pkg.
module emb_out (
  input  logic               clk,
  input  logic               rst_n,
  input  emb_pkg::emb_beat_t beat_i,
  output logic               en_o,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  output logic               out_tlast
);

  logic              vld_r;
  logic              last_r;
  logic [31:0]       data_r;
  logic signed [9:0] sum;
  logic [7:0]        gray;

  // pipeline moves whenever the result register is free or being taken
  assign en_o = !vld_r | out_tready;

  assign sum = 10'sd128 + {beat_i.best[8], beat_i.best};

  always_comb begin
    priority if (beat_i.flat) begin
      gray = emb_pkg::GRAY_MID;
    end else if (sum < 0) begin
      gray = '0;
    end else if (sum > 10'sd255) begin
      gray = emb_pkg::GRAY_MAX;
    end else begin
      gray = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en_o) begin
      vld_r <= beat_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      last_r <= beat_i.last;
      data_r <= {gray, gray, gray, beat_i.alpha};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

### rtl/emboss_gray_filter.sv
// Emboss filter top level: front stage, row of channel cells, output stage.
// Depends on emb_pkg, emb_front, emb_cell and emb_out.
//
//   port group   direction  beat contents
//   in_          slave      tdata[31:0] pixel_in (R 31:24, G 23:16, B 15:8, A 7:0)
//   out_         master     tdata[31:0] pixel_out, tlast frame_last
//   cfg_         write      addr 0 frame_width, addr 1 frame_height
//
// One pixel per clock sustained while the output is not stalled; registers are the
// front stage, three channel cells and the result register. The line store has one
// read-before-write port used once per beat. Reset is synchronous and active low;
// the line store is not cleared. A stalled result register holds the whole pipeline
// and drops in_tready in the same cycle.
module emboss_gray_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,   // pixel_in [31:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // pixel_out [31:0]
  output logic                       out_tlast,
  input  logic                       cfg_wen,
  input  logic                       cfg_addr,
  input  logic [emb_pkg::CFG_DW-1:0] cfg_wdata
);

  emb_pkg::emb_beat_t chain [emb_pkg::NCH+1];
  logic               en;

  emb_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .beat_o    (chain[0])
  );

  // red, green, blue cells in turn
  for (genvar i = 0; i < emb_pkg::NCH; i++) begin : g_cell
    emb_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .beat_i (chain[i]),
      .beat_o (chain[i+1])
    );
  end

  emb_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_i     (chain[emb_pkg::NCH]),
    .en_o       (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assign in_tready = en;

endmodule

### tb/tb_top.sv
// Self-checking bench for emboss_gray_filter: stream stimulus, a cycle-free pixel
// predictor and a scoreboard on the result stream. Depends on emb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int DRAIN_CYCLES = 8;      // pipeline is five deep
  localparam int STALL_LEN    = 300;    // long receiver hold-off
  localparam int STALL_BURST  = 24;
  localparam int RANDOM_ITEMS = 120;
  localparam int LINE_DEPTH   = 1024;

  typedef struct {
    logic [31:0] pixel;
    logic        last;
  } emboss_result_t;

  // DUT ports
  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [31:0]                in_tdata   = '0;   // pixel_in [31:0]
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [31:0]                out_tdata;         // pixel_out [31:0]
  logic                       out_tlast;
  logic                       cfg_wen    = 1'b0;
  logic                       cfg_addr   = emb_pkg::CFG_FRAME_WIDTH;
  logic [emb_pkg::CFG_DW-1:0] cfg_wdata  = '0;

  // Predictor state
  logic [10:0] width_reg  = 11'd1024;
  logic [15:0] height_reg = 16'd1024;
  logic [23:0] row_mem [LINE_DEPTH];
  logic [23:0] ul_hold    = '0;
  logic [9:0]  col_cnt    = '0;
  logic [15:0] row_cnt    = '0;
  int          stored_cols = 0;    // line entries 0..stored_cols-1 have been written
  logic        frame_done = 1'b0;

  emboss_result_t pending_pixels[$];
  emboss_result_t due;

  // Run control and tallies
  logic quiet     = 1'b0;
  logic stall_req = 1'b0;
  int   fails = 0, pixels_sent = 0, frames_seen = 0, cfg_writes = 0, beats_checked = 0;
  int   hold_left = 0, sink_wait = 0;

  emboss_gray_filter DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_wen, .cfg_addr, .cfg_wdata
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int spread(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Largest upper-left minus pixel difference, ties to red then green, clamped
  function automatic logic [7:0] emboss_level(input logic [23:0] cur,
                                              input logic [23:0] ul);
    int dr, dg, db, d, g;
    dr = int'(ul[23:16]) - int'(cur[23:16]);
    dg = int'(ul[15:8])  - int'(cur[15:8]);
    db = int'(ul[7:0])   - int'(cur[7:0]);
    d  = dr;
    if (spread(dg) > spread(d)) d = dg;
    if (spread(db) > spread(d)) d = db;
    g = int'(emb_pkg::GRAY_MID) + d;
    if (g < 0) g = 0;
    if (g > int'(emb_pkg::GRAY_MAX)) g = int'(emb_pkg::GRAY_MAX);
    return g[7:0];
  endfunction

  // One accepted pixel: advance the line store and counters, queue the result
  function automatic void predict_emboss(input logic [31:0] px);
    int             w, h;
    logic [23:0]    rgb, ul;
    logic [7:0]     gray;
    logic           row_end;
    emboss_result_t res;
    rgb = px[31:8];
    w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg));
    h = (height_reg == 0) ? 1 : int'(height_reg);
    ul = ul_hold;
    ul_hold = row_mem[col_cnt];
    row_mem[col_cnt] = rgb;
    if (int'(col_cnt) + 1 > stored_cols) stored_cols = int'(col_cnt) + 1;
    gray = (row_cnt == 0 || col_cnt == 0) ? emb_pkg::GRAY_MID : emboss_level(rgb, ul);
    row_end = int'(col_cnt) >= w - 1;
    res.last = row_end && (int'(row_cnt) >= h - 1);
    res.pixel = {gray, gray, gray, px[7:0]};
    if (row_end) begin
      col_cnt = '0;
      row_cnt = res.last ? 16'd0 : row_cnt + 16'd1;
    end else begin
      col_cnt = col_cnt + 10'd1;
    end
    frame_done = res.last;
    if (res.last) frames_seen++;
    pending_pixels.push_back(res);
  endfunction

  // Random pixel, half the time with channels from the edges of the range
  function automatic logic [31:0] pick_pixel();
    logic [31:0] px;
    int          i;
    px = $urandom;
    if ($urandom_range(0, 1)) begin
      for (i = 1; i < 4; i++) begin
        case ($urandom_range(0, 5))
          0: px[8*i +: 8] = 8'h00;
          1: px[8*i +: 8] = 8'hFF;
          2: px[8*i +: 8] = 8'h80;
          3: px[8*i +: 8] = 8'h7F;
          4: px[8*i +: 8] = 8'h01;
          default: ;
        endcase
      end
    end
    return px;
  endfunction

  // Offer one beat, hold tvalid until it is taken
  task automatic send_pixel(input logic [31:0] px);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    predict_emboss(px);
  endtask

  // Stop offering and wait until every result is out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [emb_pkg::CFG_DW-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    if (idx == emb_pkg::CFG_FRAME_WIDTH) width_reg = val[10:0];
    else height_reg = val;
    cfg_writes++;
  endtask

  task automatic finish_frame();
    do send_pixel(pick_pixel()); while (!frame_done);
  endtask

  // Reset size: first row only, all mid gray, alpha through
  task automatic test_reset_size();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h00FF_00FF);
    send_pixel(32'hFF00_FF00);
    send_pixel(pick_pixel());
    send_pixel(pick_pixel());
  endtask

  // Zero width and height behave as one; written in mid-row
  task automatic test_degenerate_size();
    drain();
    write_reg(emb_pkg::CFG_FRAME_WIDTH, 16'hF800);
    write_reg(emb_pkg::CFG_FRAME_HEIGHT, 16'h0000);
    repeat (4) send_pixel(pick_pixel());
  endtask

  // Two-column frame: each right-hand pixel sees the left pixel of the row above
  task automatic test_channel_select();
    logic [23:0] ul_set  [8] = '{24'hFFFFFF, 24'h000000, 24'h10F080, 24'h8010F0,
                                 24'h404000, 24'h7F0000, 24'h808080, 24'h20C040};
    logic [23:0] cur_set [8] = '{24'h000000, 24'hFFFFFF, 24'h20E080, 24'h8020E0,
                                 24'h40407F, 24'h000000, 24'h808080, 24'h202040};
    int k;
    drain();
    write_reg(emb_pkg::CFG_FRAME_WIDTH, 16'd2);
    write_reg(emb_pkg::CFG_FRAME_HEIGHT, 16'd9);
    send_pixel({ul_set[0], 8'h00});
    send_pixel(32'hFFFF_FFFF);
    for (k = 0; k < 8; k++) begin
      send_pixel({(k < 7) ? ul_set[k + 1] : 24'h000000, 8'($urandom)});
      send_pixel({cur_set[k], 8'($urandom)});
    end
  endtask

  // Width field at its top value saturates to a full 1024-pixel line
  task automatic test_widest_rows();
    drain();
    write_reg(emb_pkg::CFG_FRAME_WIDTH, 16'hFFFF);
    write_reg(emb_pkg::CFG_FRAME_HEIGHT, 16'd1);
    finish_frame();
  endtask

  // Narrow, shorten and widen while a frame is in progress
  task automatic test_size_change_mid_frame();
    drain();
    write_reg(emb_pkg::CFG_FRAME_WIDTH, 16'd5);
    write_reg(emb_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
    repeat (17) send_pixel(pick_pixel());
    drain();
    write_reg(emb_pkg::CFG_FRAME_WIDTH, 16'd3);
    repeat (5) send_pixel(pick_pixel());
    drain();
    write_reg(emb_pkg::CFG_FRAME_HEIGHT, 16'd2);
    send_pixel(pick_pixel());
    drain();
    // every column of the wider row was written by the full-line frame
    write_reg(emb_pkg::CFG_FRAME_WIDTH, 16'd6);
    finish_frame();
  endtask

  // Receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_output_stall();
    drain();
    quiet = 1'b1;
    stall_req = 1'b1;
    repeat (STALL_BURST) send_pixel(pick_pixel());
    quiet = 1'b0;
  endtask

  // Resize mid-frame; widen only over line entries that hold data
  task automatic resize_in_frame();
    int w;
    drain();
    w = $urandom_range(1, 40);
    if (row_cnt != 0 && w > stored_cols) w = stored_cols;
    if ($urandom_range(0, 1)) write_reg(emb_pkg::CFG_FRAME_WIDTH, 16'(w));
    write_reg(emb_pkg::CFG_FRAME_HEIGHT, 16'($urandom_range(1, 8)));
  endtask

  // Whole frames of random size and content, some resized part way through
  task automatic test_random_frames();
    int goal, w, h, r, cut, n;
    goal = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < goal) begin
      r = $urandom_range(0, 99);
      w = (r < 70) ? $urandom_range(1, 8) : ((r < 95) ? $urandom_range(9, 40)
                                                       : $urandom_range(100, 300));
      h = (w > 40) ? 1 : $urandom_range(1, 6);
      drain();
      quiet = ($urandom_range(0, 4) == 0);
      write_reg(emb_pkg::CFG_FRAME_WIDTH,
                {5'($urandom), (w == 1 && $urandom_range(0, 1)) ? 11'd0 : 11'(w)});
      write_reg(emb_pkg::CFG_FRAME_HEIGHT,
                (h == 1 && $urandom_range(0, 1)) ? 16'd0 : 16'(h));
      cut = (w * h > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, w * h - 1) : -1;
      n = 0;
      do begin
        send_pixel(pick_pixel());
        n++;
        if (n == cut && !frame_done) resize_in_frame();
      end while (!frame_done);
    end
    quiet = 1'b0;
  endtask

  // Receiver ready: forced hold-off on request, otherwise random gaps
  always @(posedge clk) begin
    if (stall_req) begin
      stall_req = 1'b0;
      hold_left = STALL_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      sink_wait = idle_gap();
    end
  end

  // Result scoreboard: every output beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("result beat with nothing expected: pixel_out %h frame_last %b",
               out_tdata, out_tlast);
        fails++;
      end else begin
        due = pending_pixels.pop_front();
        beats_checked++;
        if (out_tdata !== due.pixel) begin
          $error("pixel_out mismatch: expected %h, actual %h", due.pixel, out_tdata);
          fails++;
        end
        if (out_tlast !== due.last) begin
          $error("frame_last mismatch: expected %b, actual %b", due.last, out_tlast);
          fails++;
        end
      end
    end
  end

  // Test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_degenerate_size();
    test_channel_select();
    test_widest_rows();
    test_size_change_mid_frame();
    test_output_stall();
    test_random_frames();
    drain();
    $display("covered %0d pixels in %0d frames with %0d register writes; %0d beats checked",
             pixels_sent, frames_seen, cfg_writes, beats_checked);
    $display("sizes from 1x1 to full 1024-pixel lines, mid-frame resizes, long output stall");
    if (fails == 0 && pending_pixels.size() == 0)
      $display("emboss_gray_filter regression: pass");
    else
      $display("emboss_gray_filter regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $error("timeout with %0d results outstanding", pending_pixels.size());
    $display("emboss_gray_filter regression: fail");
    $finish;
  end

endmodule
